@@ src/pcse_pkg.sv @@
// ----------------------------------------------------------------------------
// pcse_pkg
// Shared types and constants of the square-wave channel with sweep.
// ----------------------------------------------------------------------------
package pcse_pkg;

  localparam int unsigned LengthMax = 64;
  localparam logic [10:0] FreqLimit = 11'h7FF;

  typedef enum logic [2:0] {
    ACT_WRITE = 3'd0,
    ACT_READ  = 3'd1,
    ACT_FRAME = 3'd2,
    ACT_TICK  = 3'd3,
    ACT_POFF  = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    REG_SWEEP = 3'd0,
    REG_DUTY  = 3'd1,
    REG_ENV   = 3'd2,
    REG_FLOW  = 3'd3,
    REG_FHIGH = 3'd4
  } reg_e;

  // operations of the shared sweep unit
  typedef enum logic [1:0] {
    SOP_TRIG  = 2'd0,
    SOP_CLOCK = 2'd1,
    SOP_CHECK = 2'd2
  } sweep_op_e;

  // request and answer between sequencer and sweep unit
  typedef struct packed {
    logic [10:0] freq;
    logic [2:0]  shift;
    logic        down;
  } sweep_req_t;

  typedef struct packed {
    logic [11:0] target;
    logic        over;
  } sweep_rsp_t;

endpackage

@@ src/pcse_sweep_unit.sv @@
// ----------------------------------------------------------------------------
// pcse_sweep_unit
// Shared sweep adder: shifted add or subtract of the shadow frequency.
// ----------------------------------------------------------------------------
module pcse_sweep_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pcse_pkg::sweep_req_t req_i,
  output pcse_pkg::sweep_rsp_t rsp_o
);
  import pcse_pkg::*;

  logic [10:0] delta;
  logic [11:0] sum;
  sweep_rsp_t  rsp_q, rsp_d;

  // one add or subtract per cycle
  always_comb begin
    delta = req_i.freq >> req_i.shift;
    if (req_i.down) begin
      sum = {1'b0, req_i.freq} - {1'b0, delta};
    end else begin
      sum = {1'b0, req_i.freq} + {1'b0, delta};
    end
    rsp_d.target = sum;
    rsp_d.over   = sum > {1'b0, FreqLimit};
  end

  // registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_q <= '0;
    end else begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

@@ src/pulse_channel_sweep_envelope_top.sv @@
// ----------------------------------------------------------------------------
// pulse_channel_sweep_envelope_top
// Square-wave sound channel with frequency sweep, length and envelope.
// ----------------------------------------------------------------------------
// Usage: one input transfer carries an action (register write or read, frame
// sequencer clock, tick, power off) with its fields; every action gives one
// output transfer with the read-back byte and the channel status.
// The block takes one item at a time. An item passes from S_IDLE through
// S_EXEC to S_OUT; a tick also walks S_TICK, and each use of the shared
// sweep adder adds S_SWAIT and S_SRES (a trigger uses it once, a sweep
// clock may use it twice). The result then sits in the output register until
// taken.
// in_stall_o is high while an item is in work or a result is waiting.
// A tick walks the period timer one reload per cycle, so the time a tick is in
// work grows with the number of duty steps it crosses (up to 16 steps at a zero
// timer, tick_cycles_i at 63 and the highest frequency).
// Reset clears all channel state, length included. While out_stall_i is
// high the result holds and no new item is taken.
// ----------------------------------------------------------------------------
module pulse_channel_sweep_envelope_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] action_i,
  input  logic [2:0] reg_index_i,
  input  logic [7:0] write_data_i,
  input  logic [2:0] seq_step_i,
  input  logic [5:0] tick_cycles_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic       channel_active_o,
  output logic [3:0] current_volume_o,
  output logic [1:0] duty_select_o,
  output logic [2:0] duty_position_o
);
  import pcse_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_SWAIT = 6'b000100,
    S_SRES  = 6'b001000,
    S_TICK  = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q;

  // latched item
  logic [2:0] act_q, idx_q, step_q;
  logic [7:0] data_q;
  logic [5:0] cyc_q;

  // channel state
  logic        chan_on_q, dac_on_q, sweep_down_q, sweep_active_q, down_used_q;
  logic [2:0]  sweep_period_q, sweep_shift_q, env_period_q, env_cnt_q, wave_q;
  logic [3:0]  sweep_cnt_q, env_start_q, vol_q;
  logic        env_up_q, length_on_q;
  logic [10:0] shadow_q, freq_q;
  logic [1:0]  duty_q;
  logic [6:0]  len_q;
  logic [14:0] timer_q;
  logic signed [16:0] t_q;
  logic [7:0]  rd_q;
  sweep_op_e   sop_q;

  sweep_req_t req;
  sweep_rsp_t rsp;

  pcse_sweep_unit u_sweep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign req.freq  = shadow_q;
  assign req.shift = sweep_shift_q;
  assign req.down  = sweep_down_q;

  logic [14:0] reload;
  assign reload = {1'b0, (12'd2048 - {1'b0, freq_q}), 2'b0} ;

  logic [3:0] sweep_rl;
  assign sweep_rl = (sweep_period_q != 3'd0) ? {1'b0, sweep_period_q} : 4'd8;

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign read_data_o = rd_q;
  assign channel_active_o = chan_on_q & dac_on_q;
  assign current_volume_o = vol_q;
  assign duty_select_o = duty_q;
  assign duty_position_o = wave_q;

  logic acc;
  assign acc = in_valid_i && !in_stall_o;

  // sequencer and channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [3:0] sc;
    logic [2:0] ec;
    logic [6:0] ln;
    logic       odd, ne, tr;
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q <= '0; idx_q <= '0; step_q <= '0; data_q <= '0; cyc_q <= '0;
      chan_on_q <= 1'b0; dac_on_q <= 1'b0; sweep_down_q <= 1'b0;
      sweep_active_q <= 1'b0; down_used_q <= 1'b0; sweep_period_q <= '0;
      sweep_shift_q <= '0; env_period_q <= '0; env_cnt_q <= '0; wave_q <= '0;
      sweep_cnt_q <= '0; env_start_q <= '0; vol_q <= '0; env_up_q <= 1'b0;
      length_on_q <= 1'b0; shadow_q <= '0; freq_q <= '0; duty_q <= '0;
      len_q <= '0; timer_q <= '0; t_q <= '0; rd_q <= 8'hFF; sop_q <= SOP_TRIG;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            act_q <= action_i; idx_q <= reg_index_i; data_q <= write_data_i;
            step_q <= seq_step_i; cyc_q <= tick_cycles_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          rd_q <= 8'hFF;
          state_q <= S_OUT;
          case (act_q)
            ACT_WRITE: begin
              unique case (idx_q)
                REG_SWEEP: begin
                  sweep_period_q <= data_q[6:4];
                  sweep_down_q <= data_q[3];
                  sweep_shift_q <= data_q[2:0];
                  if (down_used_q && sweep_down_q && !data_q[3]) chan_on_q <= 1'b0;
                end
                REG_DUTY: begin
                  duty_q <= data_q[7:6];
                  len_q <= 7'(LengthMax) - {1'b0, data_q[5:0]};
                end
                REG_ENV: begin
                  dac_on_q <= (data_q[7:3] != 5'd0);
                  if (data_q[7:3] == 5'd0) chan_on_q <= 1'b0;
                  env_start_q <= data_q[7:4];
                  env_up_q <= data_q[3];
                  env_period_q <= data_q[2:0];
                end
                REG_FLOW: freq_q[7:0] <= data_q;
                REG_FHIGH: begin
                  ne = data_q[6]; tr = data_q[7]; odd = step_q[0];
                  ln = len_q;
                  freq_q[10:8] <= data_q[2:0];
                  if (!length_on_q && ne && odd && ln != 7'd0) begin
                    ln = ln - 7'd1;
                    if (ln == 7'd0 && !tr) chan_on_q <= 1'b0;
                  end
                  length_on_q <= ne;
                  if (tr && ln == 7'd0) begin
                    ln = 7'(LengthMax);
                    if (ne && odd) ln = ln - 7'd1;
                  end
                  len_q <= ln;
                  if (tr) begin
                    chan_on_q <= dac_on_q;
                    vol_q <= env_start_q;
                    env_cnt_q <= env_period_q;
                    timer_q <= {1'b0, (12'd2048 - {1'b0, data_q[2:0], freq_q[7:0]}), 2'b0};
                    shadow_q <= {data_q[2:0], freq_q[7:0]};
                    sweep_cnt_q <= sweep_rl;
                    sweep_active_q <= (sweep_period_q != 3'd0) || (sweep_shift_q != 3'd0);
                    down_used_q <= 1'b0;
                    if (sweep_shift_q != 3'd0) begin
                      sop_q <= SOP_CHECK;
                      state_q <= S_SWAIT;
                    end
                  end
                end
                default: ;
              endcase
            end
            ACT_READ: begin
              unique case (idx_q)
                REG_SWEEP: rd_q <= {1'b1, sweep_period_q, sweep_down_q, sweep_shift_q};
                REG_DUTY:  rd_q <= {duty_q, 6'h3F};
                REG_ENV:   rd_q <= {env_start_q, env_up_q, env_period_q};
                REG_FHIGH: rd_q <= {1'b1, length_on_q, 6'h3F};
                default:   rd_q <= 8'hFF;
              endcase
            end
            ACT_FRAME: begin
              if (!step_q[0] && length_on_q && len_q != 7'd0) begin
                len_q <= len_q - 7'd1;
                if (len_q == 7'd1) chan_on_q <= 1'b0;
              end
              if (step_q == 3'd2 || step_q == 3'd6) begin
                sc = sweep_cnt_q;
                if (sc != 4'd0) sc = sc - 4'd1;
                if (sc == 4'd0) begin
                  sc = sweep_rl;
                  if (sweep_active_q && sweep_period_q != 3'd0) begin
                    sop_q <= SOP_CLOCK;
                    state_q <= S_SWAIT;
                  end
                end
                sweep_cnt_q <= sc;
              end
              if (step_q == 3'd7 && env_period_q != 3'd0) begin
                ec = env_cnt_q;
                if (ec != 3'd0) ec = ec - 3'd1;
                if (ec == 3'd0) begin
                  ec = env_period_q;
                  if (env_up_q && vol_q != 4'd15) vol_q <= vol_q + 4'd1;
                  else if (!env_up_q && vol_q != 4'd0) vol_q <= vol_q - 4'd1;
                end
                env_cnt_q <= ec;
              end
            end
            ACT_TICK: begin
              t_q <= $signed({2'b0, timer_q}) - $signed({11'b0, cyc_q});
              state_q <= S_TICK;
            end
            ACT_POFF: begin
              chan_on_q <= 1'b0; dac_on_q <= 1'b0; sweep_period_q <= '0;
              sweep_down_q <= 1'b0; sweep_shift_q <= '0; sweep_active_q <= 1'b0;
              sweep_cnt_q <= '0; shadow_q <= '0; down_used_q <= 1'b0;
              duty_q <= '0; env_start_q <= '0; env_up_q <= 1'b0;
              env_period_q <= '0; env_cnt_q <= '0; vol_q <= '0; freq_q <= '0;
              length_on_q <= 1'b0; timer_q <= '0; wave_q <= '0;
            end
            default: ;
          endcase
        end
        // adder input is latched this cycle
        S_SWAIT: begin
          if (sweep_down_q) down_used_q <= 1'b1;
          state_q <= S_SRES;
        end
        S_SRES: begin
          state_q <= S_OUT;
          unique case (sop_q)
            SOP_CHECK: if (rsp.over) chan_on_q <= 1'b0;
            SOP_CLOCK: begin
              if (rsp.over) begin
                chan_on_q <= 1'b0;
              end else if (sweep_shift_q != 3'd0) begin
                shadow_q <= rsp.target[10:0];
                freq_q <= rsp.target[10:0];
                sop_q <= SOP_CHECK;
                state_q <= S_SWAIT;
              end
            end
            default: ;
          endcase
        end
        // one timer reload per cycle
        S_TICK: begin
          if (t_q <= 17'sd0) begin
            t_q <= t_q + $signed({2'b0, reload});
            wave_q <= wave_q + 3'd1;
          end else begin
            timer_q <= t_q[14:0];
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // checks
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(rd_q))
    else $error("result lost under stall");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> in_stall_o) else $error("ready while busy");
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= 7'(LengthMax)) else $error("length out of range");

endmodule
